// File: sv/propagation_arrival_step_unit_assert.svh
// Assertion macros for the arrival step unit
`ifndef PROPAGATION_ARRIVAL_STEP_UNIT_ASSERT_SVH
`define PROPAGATION_ARRIVAL_STEP_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define PAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define PAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pas_pkg.sv
`timescale 1ns / 1ps
package pas_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int SPEED_W        = 24;
  localparam int STEP_W         = 32;
  localparam int DEN_W          = SPEED_W + STEP_W;
  localparam int CNT_W          = 64;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [STEP_W-1:0] STEP_RESET  = 32'd16777;
  localparam logic [11:0]       SPEED_NUM   = 12'd3432;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NOP   = 2'd3
  } pas_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_PREP,
    ST_DIV,
    ST_ADD,
    ST_DONE
  } pas_state_t;

  typedef struct packed {
    logic is_query;
    logic use_default;
  } pas_ctl_t;

endpackage

// File: sv/pas_intf.sv
`timescale 1ns / 1ps
interface pas_in_if #(parameter int COORD_BITS = 24);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [63:0]           time_value;
  logic signed [COORD_BITS-1:0] x_source;
  logic signed [COORD_BITS-1:0] y_source;
  logic signed [COORD_BITS-1:0] x_target;
  logic signed [COORD_BITS-1:0] y_target;
  logic                  use_default_speed;
  logic [23:0]           wave_speed;

  modport source (output valid, action, time_value, x_source, y_source, x_target,
                  y_target, use_default_speed, wave_speed, input ready);
  modport sink (input valid, action, time_value, x_source, y_source, x_target,
                y_target, use_default_speed, wave_speed, output ready);
endinterface

interface pas_out_if #(parameter int COORD_BITS = 24);
  logic                valid;
  logic                ready;
  logic [63:0]         arrival_step;
  logic [COORD_BITS:0] path_length;
  logic [63:0]         current_step;
  logic                zero_divisor;

  modport source (output valid, arrival_step, path_length, current_step, zero_divisor,
                  input ready);
  modport sink (input valid, arrival_step, path_length, current_step, zero_divisor,
                output ready);
endinterface

// File: sv/propagation_arrival_step_unit.sv
`timescale 1ns / 1ps
// channel | dir | handshake       | word
// in_ch   | in  | valid/ready     | action, time, coordinates, speed
// out_ch  | out | valid/ready     | arrival step, path length, counter, flag
// cfg     | in  | cfg_we          | step_seconds, Q8.24
// Tick, load and no-op words pass the back end through IDLE and DONE; a query
// also runs SQUARE, SUM, ROOT, PREP, DIV and ADD, for the serial square root and
// the bit-serial divider in the back end (DIV is skipped on a zero divisor).
// The result is registered in DONE, which waits while the output is stalled.
// A two-word queue lets the front accept while the back end works or stalls.
// Reset clears the counter and the queue and sets the step length to about 1 ms.
module propagation_arrival_step_unit #(
  parameter int COORD_BITS = pas_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pas_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  pas_in_if.sink                     in_ch,
  pas_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [pas_pkg::STEP_W-1:0] cfg_wdata
);
  import pas_pkg::*;

  localparam int QW = 2 + CNT_W + 2 * (COORD_BITS + 1) + SPEED_W;

  logic [STEP_W-1:0] step_r;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0]     push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_we) begin
      step_r <= cfg_wdata;
    end
  end

  pas_front #(.COORD_BITS(COORD_BITS), .QW(QW)) u_front (
    .clk, .rst_n, .in_ch,
    .push_valid, .push_ready, .push_data
  );

  pas_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst_n,
    .push_valid, .push_ready, .push_data,
    .pop_valid, .pop_ready, .pop_data
  );

  pas_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .QW(QW)) u_back (
    .clk, .rst_n, .step_seconds(step_r),
    .pop_valid, .pop_ready, .pop_data, .out_ch
  );

endmodule

// File: sv/pas_queue.sv
`timescale 1ns / 1ps
module pas_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  import pas_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: sv/pas_front.sv
`timescale 1ns / 1ps
module pas_front #(
  parameter int COORD_BITS = pas_pkg::COORD_BITS_DEF,
  parameter int QW         = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  pas_in_if.sink        in_ch,
  output logic          push_valid,
  input  logic          push_ready,
  output logic [QW-1:0] push_data
);
  import pas_pkg::*;

  localparam int DW = COORD_BITS + 1;

  logic [CNT_W-1:0] counter_r, counter_nxt;
  logic             accept;
  pas_ctl_t         ctl;
  logic signed [DW-1:0] xs, xt, ys, yt;
  logic [DW-1:0]    dx, dy;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  always_comb begin
    counter_nxt = counter_r;
    case (pas_action_t'(in_ch.action))
      ACT_TICK:  counter_nxt = counter_r + 1'b1;
      ACT_LOAD:  counter_nxt = in_ch.time_value;
      default:   counter_nxt = counter_r;
    endcase
  end

  always_comb begin
    xs = DW'(in_ch.x_source);
    xt = DW'(in_ch.x_target);
    ys = DW'(in_ch.y_source);
    yt = DW'(in_ch.y_target);
    dx = (xs >= xt) ? DW'(xs - xt) : DW'(xt - xs);
    dy = (ys >= yt) ? DW'(ys - yt) : DW'(yt - ys);
    ctl.is_query    = (pas_action_t'(in_ch.action) == ACT_QUERY);
    ctl.use_default = in_ch.use_default_speed;
  end

  assign push_valid = in_ch.valid;
  assign push_data  = {ctl, counter_nxt, dx, dy, in_ch.wave_speed};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
    end else if (accept) begin
      counter_r <= counter_nxt;
    end
  end

endmodule

// File: sv/pas_back.sv
`timescale 1ns / 1ps
`include "propagation_arrival_step_unit_assert.svh"
module pas_back #(
  parameter int COORD_BITS = pas_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pas_pkg::FRAC_BITS_DEF,
  parameter int QW         = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [pas_pkg::STEP_W-1:0] step_seconds,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  logic [QW-1:0]             pop_data,
  pas_out_if.source                 out_ch
);
  import pas_pkg::*;

  localparam int DW   = COORD_BITS + 1;
  localparam int SQW  = 2 * DW;
  localparam int RW   = DW;
  localparam int RMW  = RW + 2;
  localparam int NW   = RW + 32 - FRAC_BITS;
  localparam int SH_D = 24 - FRAC_BITS;
  localparam int SH_G = 32 - FRAC_BITS;
  localparam int IW   = $clog2(NW);

  pas_state_t       state_r, state_nxt;
  pas_ctl_t         ctl_r, pop_ctl;
  logic [CNT_W-1:0] cnt_r, pop_cnt;
  logic [DW-1:0]    dx_r, dy_r, pop_dx, pop_dy;
  logic [SPEED_W-1:0] spd_r, pop_spd;
  logic [SQW-1:0]   sqx_r, sqy_r, rad_r;
  logic [DEN_W-1:0] den_r, drem_r;
  logic [RMW-1:0]   rem_r, rem_t, trial;
  logic [RW-1:0]    root_r;
  logic [NW-1:0]    num_r;
  logic [DEN_W:0]   dtrial;
  logic [IW-1:0]    iter_r;
  logic             zf_r;
  logic [CNT_W-1:0] arr_r;
  logic [CNT_W:0]   sum;
  logic [NW-1:0]    root_ext;
  logic             load_out, last_root, last_div;

  logic             out_valid_r;
  logic [CNT_W-1:0] out_arr_r, out_cur_r;
  logic [RW-1:0]    out_len_r;
  logic             out_zf_r;

  assign {pop_ctl, pop_cnt, pop_dx, pop_dy, pop_spd} = pop_data;

  assign rem_t     = {rem_r[RMW-3:0], rad_r[SQW-1 -: 2]};
  assign trial     = {root_r, 2'b01};
  assign dtrial    = {drem_r, num_r[NW-1]};
  assign root_ext  = NW'(root_r);
  assign sum       = {1'b0, cnt_r} + (CNT_W + 1)'(num_r);
  assign last_root = (iter_r == IW'(RW - 1));
  assign last_div  = (iter_r == IW'(NW - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (pop_valid) state_nxt = pop_ctl.is_query ? ST_SQUARE : ST_DONE;
      ST_SQUARE: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_ROOT;
      ST_ROOT:   if (last_root) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = zf_r ? ST_ADD : ST_DIV;
      ST_DIV:    if (last_div) state_nxt = ST_ADD;
      ST_ADD:    state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: pop_ready = 1'b1;
      ST_DONE: load_out  = !out_valid_r || out_ch.ready;
      default: begin
        pop_ready = 1'b0;
        load_out  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        ctl_r <= pop_ctl;
        cnt_r <= pop_cnt;
        dx_r  <= pop_dx;
        dy_r  <= pop_dy;
        spd_r <= pop_spd;
      end
      ST_SQUARE: begin
        sqx_r <= SQW'(dx_r * dx_r);
        sqy_r <= SQW'(dy_r * dy_r);
        den_r <= ctl_r.use_default ? DEN_W'(SPEED_NUM * step_seconds)
                                   : DEN_W'(spd_r * step_seconds);
      end
      ST_SUM: begin
        rad_r  <= sqx_r + sqy_r;
        rem_r  <= '0;
        root_r <= '0;
        iter_r <= '0;
        zf_r   <= (den_r == '0);
      end
      ST_ROOT: begin
        rad_r  <= rad_r << 2;
        iter_r <= iter_r + 1'b1;
        if (rem_t >= trial) begin
          rem_r  <= rem_t - trial;
          root_r <= {root_r[RW-2:0], 1'b1};
        end else begin
          rem_r  <= rem_t;
          root_r <= {root_r[RW-2:0], 1'b0};
        end
      end
      ST_PREP: begin
        num_r  <= ctl_r.use_default ? NW'(((root_ext << SH_D) << 3) + ((root_ext << SH_D) << 1))
                                    : NW'(root_ext << SH_G);
        drem_r <= '0;
        iter_r <= '0;
      end
      ST_DIV: begin
        iter_r <= iter_r + 1'b1;
        if (dtrial >= {1'b0, den_r}) begin
          drem_r <= DEN_W'(dtrial - {1'b0, den_r});
          num_r  <= {num_r[NW-2:0], 1'b1};
        end else begin
          drem_r <= DEN_W'(dtrial);
          num_r  <= {num_r[NW-2:0], 1'b0};
        end
      end
      ST_ADD: begin
        arr_r <= (zf_r || sum[CNT_W]) ? '1 : sum[CNT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_cur_r <= cnt_r;
      out_arr_r <= ctl_r.is_query ? arr_r  : '0;
      out_len_r <= ctl_r.is_query ? root_r : '0;
      out_zf_r  <= ctl_r.is_query && zf_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.arrival_step = out_arr_r;
  assign out_ch.path_length  = out_len_r;
  assign out_ch.current_step = out_cur_r;
  assign out_ch.zero_divisor = out_zf_r;

  `PAS_ASSERT_NOW(a_zero_sat, out_valid_r && out_zf_r, out_arr_r == '1, "zero divisor not saturated")
  `PAS_ASSERT_NOW(a_pop_idle, pop_ready, state_r == ST_IDLE, "queue popped while busy")
  `PAS_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ch.ready, out_valid_r && $stable(out_cur_r), "result dropped")
  `PAS_ASSERT_NEXT(a_div_end, state_r == ST_DIV && last_div, state_r == ST_ADD, "divider overran")

endmodule
